@@ hw/rtl/losc_pkg.sv @@
`timescale 1ns / 1ps

package losc_pkg;

  localparam int STATUS_W = 3;
  localparam int HELD_W   = 5;
  localparam int LEVEL_W  = 32;
  localparam int COUNT_W  = 64;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd5;

endpackage

@@ hw/rtl/losc_stack_mem.sv @@
`timescale 1ns / 1ps

module losc_stack_mem
  import losc_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [LEVEL_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [LEVEL_W-1:0] rd_data
);

  logic [LEVEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/lock_order_stack_checker.sv @@
`timescale 1ns / 1ps

// Lock-order checker over one stack of lock levels held in a synchronous RAM.
// A command is taken on a clock edge with start high and busy low, and its
// result appears on the result ports marked by done, which is high for
// exactly one cycle and cannot be held off. An acquire, an ignored command,
// any violation and a release that empties the stack finish without entering
// S_POP, so a new command can follow on the next edge. A release that leaves
// at least one lock held must read the new top level back from the stack RAM,
// whose read port is registered; busy is high while it waits in S_POP. Only
// the top level is kept in a register, so the comparisons never wait on the
// RAM. The check_enable register is written through the cfg_valid/cfg_ready
// channel, which is always ready; write it only while no command is in flight.
module lock_order_stack_checker
  import losc_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                opcode,
  input  logic [LEVEL_W-1:0]  lock_rank,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [HELD_W-1:0]   held_depth,
  output logic [LEVEL_W-1:0]  current_level,
  output logic [COUNT_W-1:0]  violation_total,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t             state, state_next;
  logic               check_enable;
  logic [DW-1:0]      depth, depth_next;
  logic [LEVEL_W-1:0] top_level, top_level_next;
  logic [COUNT_W-1:0] violation_count, violation_count_next;
  logic               emit;
  logic [STATUS_W-1:0] status_next;

  logic               mem_wr_en;
  logic [DW-1:0]      depth_m2;
  logic [LEVEL_W-1:0] mem_rd_data;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign busy      = (state == S_POP);
  assign accept    = start && !busy;
  assign depth_m2  = depth - DW'(2);

  losc_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (depth[AW-1:0]),
    .wr_data (lock_rank),
    .rd_addr (depth_m2[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    state_next           = state;
    depth_next           = depth;
    top_level_next       = top_level;
    violation_count_next = violation_count;
    emit                 = 1'b0;
    status_next          = ST_OK;
    mem_wr_en            = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          if (!check_enable) begin
            status_next = ST_IGNORED;
          end else if (opcode == OP_ACQUIRE) begin
            if (depth >= DW'(STACK_DEPTH)) begin
              status_next          = ST_OVERFLOW;
              violation_count_next = violation_count + COUNT_W'(1);
            end else if (depth != '0 && lock_rank <= top_level) begin
              status_next          = ST_ORDER;
              violation_count_next = violation_count + COUNT_W'(1);
            end else begin
              mem_wr_en      = 1'b1;
              depth_next     = depth + DW'(1);
              top_level_next = lock_rank;
            end
          end else begin
            if (depth == '0) begin
              status_next          = ST_EMPTY;
              violation_count_next = violation_count + COUNT_W'(1);
            end else if (lock_rank != top_level) begin
              status_next          = ST_MISMATCH;
              violation_count_next = violation_count + COUNT_W'(1);
            end else begin
              depth_next = depth - DW'(1);
              if (depth == DW'(1)) begin
                top_level_next = '0;
              end else begin
                // The entry below the top arrives from the RAM next cycle.
                emit       = 1'b0;
                state_next = S_POP;
              end
            end
          end
        end
      end
      S_POP: begin
        emit           = 1'b1;
        status_next    = ST_OK;
        top_level_next = mem_rd_data;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      check_enable    <= 1'b0;
      depth           <= '0;
      top_level       <= '0;
      violation_count <= '0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      depth           <= depth_next;
      top_level       <= top_level_next;
      violation_count <= violation_count_next;
      done            <= emit;
      if (cfg_valid && cfg_ready) begin
        check_enable <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status          <= status_next;
      held_depth      <= HELD_W'(depth_next);
      current_level   <= top_level_next;
      violation_total <= violation_count_next;
    end
  end

endmodule
